@@ sv/rbd_pkg.sv @@
// Shared constants, types and register codes for the 2x2 box downsampler.
package rbd_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int LINE_DEPTH  = MAX_WIDTH / 2;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);

    localparam int SRC_WIDTH_W  = 13;
    localparam int SRC_HEIGHT_W = 16;
    localparam int ROW_W        = 16;
    localparam int YPOS_W       = ROW_W - 1;
    localparam int WEFF_W       = (SRC_WIDTH_W > COL_W + 1) ? SRC_WIDTH_W : COL_W + 1;

    localparam int CHAN_W   = 8;
    localparam int PAIR_W   = CHAN_W + 1;
    localparam int SUM_W    = CHAN_W + 2;
    localparam int NUM_CHAN = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_ADDR_W = 3;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH_IDX  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_IDX = REG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_COMBINE,
        OP_DIRECT
    } rbd_op_kind_t;

    typedef logic [NUM_CHAN-1:0][PAIR_W-1:0] rbd_pairs_t;
    typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rbd_pix_t;

    typedef struct packed {
        rbd_op_kind_t        kind;
        logic [ADDR_W-1:0]   addr;
        rbd_pairs_t          pairs;
        logic                last;
    } rbd_op_t;

endpackage

@@ sv/rbd_in_if.sv @@
// Source pixel channel: valid/ready handshake with one RGBA8 pixel.
interface rbd_in_if import rbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;

    modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
    modport sink   (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

@@ sv/rbd_out_if.sv @@
// Result pixel channel: valid/ready handshake with one averaged RGBA8 pixel.
interface rbd_out_if import rbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              frame_end;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, alpha_out, frame_end,
                    output ready);
endinterface

@@ sv/rbd_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rbd_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/rbd_front.sv @@
// Front end: tracks the raster position, forms horizontal pair sums and classifies them.
module rbd_front import rbd_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [SRC_WIDTH_W-1:0]  source_width,
    input  logic [SRC_HEIGHT_W-1:0] source_height,
    input  logic                    restart,
    rbd_in_if.sink                  pix,
    output logic                    push,
    output rbd_op_t                 op,
    input  logic                    full
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    rbd_pix_t          held_reg;

    logic [WEFF_W-1:0]       sw_ext, w_eff;
    logic [SRC_HEIGHT_W-1:0] h_eff;
    logic                    w_one, h_one;
    logic [COL_W-1:0]        last_col;
    logic [ROW_W-1:0]        last_row;
    logic [ADDR_W-1:0]       dw_m1, x;
    logic [YPOS_W-1:0]       dh_m1, y;
    logic                    x_ok, y_ok, accept, have_pair, hold_en;
    rbd_pix_t                px;

    always_comb
    begin
        sw_ext   = WEFF_W'(source_width);
        if (source_width == '0)
            w_eff = WEFF_W'(1);
        else if (sw_ext > WEFF_W'(MAX_WIDTH))
            w_eff = WEFF_W'(MAX_WIDTH);
        else
            w_eff = sw_ext;
        h_eff    = (source_height == '0) ? SRC_HEIGHT_W'(1) : source_height;
        w_one    = (w_eff == WEFF_W'(1));
        h_one    = (h_eff == SRC_HEIGHT_W'(1));
        last_col = COL_W'(w_eff - WEFF_W'(1));
        last_row = ROW_W'(h_eff - SRC_HEIGHT_W'(1));
        dw_m1    = w_one ? '0 : ADDR_W'((w_eff >> 1) - WEFF_W'(1));
        dh_m1    = h_one ? '0 : YPOS_W'((h_eff >> 1) - SRC_HEIGHT_W'(1));
        x        = col_reg[COL_W-1:1];
        y        = row_reg[ROW_W-1:1];
        x_ok     = (x <= dw_m1);
        y_ok     = (y <= dh_m1);
    end

    assign px[0] = pix.red_in;
    assign px[1] = pix.green_in;
    assign px[2] = pix.blue_in;
    assign px[3] = pix.alpha_in;

    assign pix.ready = !full;
    assign accept    = pix.valid && pix.ready;
    assign have_pair = w_one || (x_ok && col_reg[0]);
    assign hold_en   = accept && !w_one && x_ok && !col_reg[0];
    assign push      = accept && have_pair && y_ok;

    always_comb
    begin
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            if (w_one)
                op.pairs[i] = {px[i], 1'b0};
            else
                op.pairs[i] = PAIR_W'(held_reg[i]) + PAIR_W'(px[i]);
        end
        op.addr = x;
        op.last = (x == dw_m1) && (y == dh_m1);
        if (h_one)
            op.kind = OP_DIRECT;
        else if (row_reg[0])
            op.kind = OP_COMBINE;
        else
            op.kind = OP_WRITE;
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                row_next = (row_reg == last_row) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            held_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (hold_en)
                held_reg <= px;
        end
    end

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg <= last_col) else $error("Column position beyond the last column.");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= last_row) else $error("Row position beyond the last row.");

endmodule

@@ sv/rbd_queue.sv @@
// Short FIFO of classified operations between the front and back ends.
module rbd_queue import rbd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  rbd_op_t op_in,
    input  logic    pop,
    output rbd_op_t op_out,
    output logic    not_empty,
    output logic    full
);

    rbd_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign op_out    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= op_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - QCNT_W'(1);
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH)) else $error("Queue count overflow.");

endmodule

@@ sv/rbd_back.sv @@
// Back end: line buffer access, vertical sum, rounding and the output register.
module rbd_back import rbd_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_valid,
    input  rbd_op_t q_op,
    output logic    pop,
    rbd_out_if.source pix
);

    logic       a_valid_reg;
    rbd_op_t    a_op_reg;
    logic       out_valid_reg;
    rbd_pix_t   out_pix_reg;
    logic       out_last_reg;

    logic                      a_adv, a_free, wr_en, rd_en;
    logic [NUM_CHAN*PAIR_W-1:0] rd_raw;
    rbd_pairs_t                line_pairs;
    rbd_pix_t                  avg;
    logic [SUM_W-1:0]          sum;
    logic [PAIR_W-1:0]         operand;

    assign a_adv  = a_valid_reg && (!out_valid_reg || pix.ready);
    assign a_free = !a_valid_reg || a_adv;
    assign pop    = q_valid && a_free;
    assign wr_en  = pop && (q_op.kind == OP_WRITE);
    assign rd_en  = pop && (q_op.kind == OP_COMBINE);

    rbd_ram #(
        .WIDTH (NUM_CHAN * PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (q_op.addr),
        .wr_data (q_op.pairs),
        .rd_en   (rd_en),
        .rd_addr (q_op.addr),
        .rd_data (rd_raw)
    );

    assign line_pairs = rbd_pairs_t'(rd_raw);

    always_comb
    begin
        sum     = '0;
        operand = '0;
        for (int i = 0; i < NUM_CHAN; i++)
        begin
            operand = (a_op_reg.kind == OP_DIRECT) ? a_op_reg.pairs[i] : line_pairs[i];
            sum     = SUM_W'(a_op_reg.pairs[i]) + SUM_W'(operand);
            avg[i]  = CHAN_W'((sum + SUM_W'(2)) >> 2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_free)
                a_valid_reg <= pop && (q_op.kind != OP_WRITE);
            if (a_adv)
                out_valid_reg <= 1'b1;
            else if (pix.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            a_op_reg <= q_op;
        if (a_adv)
        begin
            out_pix_reg  <= avg;
            out_last_reg <= a_op_reg.last;
        end
    end

    assign pix.valid     = out_valid_reg;
    assign pix.red_out   = out_pix_reg[0];
    assign pix.green_out = out_pix_reg[1];
    assign pix.blue_out  = out_pix_reg[2];
    assign pix.alpha_out = out_pix_reg[3];
    assign pix.frame_end = out_last_reg;

    a_stall_holds_op: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && !a_adv) |=> (a_valid_reg && $stable(a_op_reg)))
        else $error("Stalled operation changed before it moved on.");

    a_read_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (a_valid_reg && a_op_reg.kind == OP_COMBINE))
        else $error("Line read without a combine operation to use it.");

endmodule

@@ sv/rgba8_box_downsample_2x2_unit.sv @@
// Top level of the RGBA8 2x2 box downsampler with its configuration registers.
// The unit takes one source pixel per clock in raster order unless the queue is full and
// returns one pixel of the next mip level for each complete 2x2 block, each channel being
// (sum of four + 2) / 4. Throughput is one source pixel per cycle while mip_pixel is not
// stalled: the back end takes one operation per cycle from a two-entry queue and uses the
// line buffer RAM (2048 entries of four 9-bit pair sums) at most once for it. A result
// passes the queue, stage A and the output register; source_pixel.ready is low while the
// queue is full. The line buffer needs no clearing after reset. Registers: source_width
// at byte address 0, source_height at byte address 4; any register write restarts the frame
// at row 0, column 0, and must be made while no transaction is in flight.
module rgba8_box_downsample_2x2_unit import rbd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    rbd_in_if.sink                source_pixel,
    rbd_out_if.source             mip_pixel,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready
);

    logic [SRC_WIDTH_W-1:0]  width_reg;
    logic [SRC_HEIGHT_W-1:0] height_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 push, pop, q_valid, q_full;
    rbd_op_t              front_op, queue_op;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH_IDX:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT_IDX: prdata = PDATA_W'(height_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= SRC_WIDTH_W'(1);
            height_reg <= SRC_HEIGHT_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_WIDTH_IDX:  width_reg  <= pwdata[SRC_WIDTH_W-1:0];
                REG_HEIGHT_IDX: height_reg <= pwdata[SRC_HEIGHT_W-1:0];
                default:        ;
            endcase
        end
    end

    rbd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .source_width  (width_reg),
        .source_height (height_reg),
        .restart       (cfg_write),
        .pix           (source_pixel),
        .push          (push),
        .op            (front_op),
        .full          (q_full)
    );

    rbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .op_in     (front_op),
        .pop       (pop),
        .op_out    (queue_op),
        .not_empty (q_valid),
        .full      (q_full)
    );

    rbd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_op    (queue_op),
        .pop     (pop),
        .pix     (mip_pixel)
    );

endmodule
